>>> rtl/core/graph_bfs_dfs_traversal_top_macros.svh
`ifndef GRAPH_BFS_DFS_TRAVERSAL_TOP_MACROS_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_TOP_MACROS_SVH

// Clocked assertion on clk_i that is switched off while rst_ni is low.
`define GBT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("graph traversal assertion failed");

// Clocked assertion that also holds during reset.
`define GBT_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("graph traversal assertion failed");

`endif

>>> rtl/core/gbt_pkg.sv
`timescale 1ns / 1ps
package gbt_pkg;

  localparam int unsigned VW     = 5;
  localparam int unsigned QD     = 32;
  localparam int unsigned QW     = 5;
  localparam int unsigned PW     = 6;
  localparam int unsigned CW     = 7;
  localparam int unsigned CFG_IW = 1;
  localparam int unsigned CFG_DW = 6;

  localparam logic [CFG_IW-1:0] REG_VERTEX_COUNT = 1'd0;
  localparam logic [CFG_IW-1:0] REG_SEARCH_MODE  = 1'd1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_RUN   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BFS_SCAN,
    ST_BFS_LOAD,
    ST_DFS_SCAN,
    ST_DFS_LOAD,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic clear;
    logic add_edge;
    logic err_out;
    logic init;
    logic enqueue;
    logic q_read;
    logic bfs_load;
    logic push;
    logic pop;
    logic dfs_load;
    logic flush;
  } ctrl_t;

  typedef struct packed {
    logic cand;
    logic q_empty;
    logic sp_one;
    logic start_bad;
    logic dfs_mode;
  } stat_t;

endpackage

>>> rtl/core/gbt_datapath.sv
`timescale 1ns / 1ps
`include "graph_bfs_dfs_traversal_top_macros.svh"
module gbt_datapath #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gbt_pkg::ctrl_t             ctrl_i,
  output gbt_pkg::stat_t             stat_o,
  input  logic                       cfg_we_i,
  input  logic [gbt_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [gbt_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic [gbt_pkg::VW-1:0]     from_vertex_i,
  input  logic [gbt_pkg::VW-1:0]     to_vertex_i,
  input  logic [gbt_pkg::VW-1:0]     start_req_i,
  output logic                       res_valid_o,
  output logic [gbt_pkg::VW-1:0]     vertex_o,
  output logic                       last_o,
  output logic                       error_o
);
  import gbt_pkg::*;

  localparam int unsigned NV = (MAX_VERTICES > 32) ? 32 : MAX_VERTICES;
  localparam int unsigned IW = $clog2(NV);

  logic [CFG_DW-1:0] vcount_q;
  logic              mode_q;
  logic [NV-1:0]     adj_q [NV];
  logic [NV-1:0]     visited_q;
  logic [VW-1:0]     cur_q;
  logic [PW-1:0]     head_q;
  logic [PW-1:0]     tail_q;
  logic [PW-1:0]     sp_q;
  logic [VW-1:0]     q_mem [QD];
  logic [VW-1:0]     s_mem [QD];
  logic [VW-1:0]     q_rd_q;
  logic [VW-1:0]     s_rd_q;
  logic [VW-1:0]     pend_q;
  logic              pend_valid_q;

  logic [CW-1:0] n_w;
  logic [NV-1:0] nmask;
  logic [NV-1:0] cand;
  logic [VW-1:0] found;
  logic          edge_ok;
  logic          emit_new;
  logic [VW-1:0] new_v;
  logic [PW-1:0] sp_m1;
  logic [PW-1:0] sp_m2;

  assign n_w = ({1'b0, vcount_q} > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                      : {1'b0, vcount_q};
  assign edge_ok = (CW'(from_vertex_i) < n_w) && (CW'(to_vertex_i) < n_w);
  assign sp_m1   = sp_q - PW'(1);
  assign sp_m2   = sp_q - PW'(2);

  always_comb begin
    for (int i = 0; i < NV; i++) begin
      nmask[i] = (CW'(i) < n_w);
    end
  end

  assign cand = adj_q[cur_q[IW-1:0]] & ~visited_q & nmask;

  always_comb begin
    found = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found = VW'(i);
      end
    end
  end

  assign stat_o.cand      = |cand;
  assign stat_o.q_empty   = (head_q == tail_q);
  assign stat_o.sp_one    = (sp_q == PW'(1));
  assign stat_o.start_bad = (CW'(start_req_i) >= n_w);
  assign stat_o.dfs_mode  = mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= CFG_DW'(32);
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VERTEX_COUNT: vcount_q <= cfg_wdata_i;
        REG_SEARCH_MODE:  mode_q   <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NV; i++) begin
        adj_q[i] <= '0;
      end
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < NV; i++) begin
        adj_q[i] <= '0;
      end
    end else if (ctrl_i.add_edge && edge_ok) begin
      for (int i = 0; i < NV; i++) begin
        adj_q[i] <= adj_q[i]
                  | ((IW'(i) == from_vertex_i[IW-1:0]) ? (NV'(1) << to_vertex_i[IW-1:0])
                                                        : '0)
                  | ((IW'(i) == to_vertex_i[IW-1:0]) ? (NV'(1) << from_vertex_i[IW-1:0])
                                                      : '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      cur_q     <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      sp_q      <= '0;
    end else begin
      if (ctrl_i.init) begin
        visited_q <= NV'(1) << start_req_i[IW-1:0];
        cur_q     <= start_req_i;
        head_q    <= '0;
        tail_q    <= '0;
        sp_q      <= PW'(1);
      end
      if (ctrl_i.enqueue) begin
        visited_q[found[IW-1:0]] <= 1'b1;
        tail_q                   <= tail_q + PW'(1);
      end
      if (ctrl_i.q_read) begin
        head_q <= head_q + PW'(1);
      end
      if (ctrl_i.bfs_load) begin
        cur_q <= q_rd_q;
      end
      if (ctrl_i.push) begin
        visited_q[found[IW-1:0]] <= 1'b1;
        cur_q                    <= found;
        sp_q                     <= sp_q + PW'(1);
      end
      if (ctrl_i.pop) begin
        sp_q <= sp_m1;
      end
      if (ctrl_i.dfs_load) begin
        cur_q <= s_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.enqueue) begin
      q_mem[tail_q[QW-1:0]] <= found;
    end
    if (ctrl_i.q_read) begin
      q_rd_q <= q_mem[head_q[QW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      s_mem[sp_m1[QW-1:0]] <= cur_q;
    end
    if (ctrl_i.pop) begin
      s_rd_q <= s_mem[sp_m2[QW-1:0]];
    end
  end

  assign emit_new = ctrl_i.init || ctrl_i.push || ctrl_i.bfs_load;

  always_comb begin
    new_v = start_req_i;
    if (ctrl_i.push) begin
      new_v = found;
    end else if (ctrl_i.bfs_load) begin
      new_v = q_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      res_valid_o  <= 1'b0;
      vertex_o     <= '0;
      last_o       <= 1'b0;
      error_o      <= 1'b0;
    end else begin
      res_valid_o <= ctrl_i.err_out || ((ctrl_i.flush || emit_new) && pend_valid_q);
      if (ctrl_i.err_out) begin
        vertex_o    <= '0;
        last_o      <= 1'b1;
        error_o     <= 1'b1;
      end else if (ctrl_i.flush) begin
        vertex_o     <= pend_q;
        last_o       <= 1'b1;
        error_o      <= 1'b0;
        pend_valid_q <= 1'b0;
      end else if (emit_new) begin
        vertex_o     <= pend_q;
        last_o       <= 1'b0;
        error_o      <= 1'b0;
        pend_q       <= new_v;
        pend_valid_q <= 1'b1;
      end
    end
  end

  `GBT_ASSERT(a_error_is_last, (res_valid_o && error_o) |-> last_o)
  `GBT_ASSERT(a_queue_order, ctrl_i.q_read |-> (head_q != tail_q))
  `GBT_ASSERT(a_stack_bound, ctrl_i.push |-> (sp_q < PW'(QD)))
  `GBT_ASSERT(a_flush_has_pending, ctrl_i.flush |-> pend_valid_q)

endmodule

>>> rtl/core/gbt_ctrl.sv
`timescale 1ns / 1ps
module gbt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [1:0]         cmd_i,
  input  gbt_pkg::stat_t     stat_i,
  output gbt_pkg::ctrl_t     ctrl_o,
  output logic               busy
);
  import gbt_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start && (cmd_i == CMD_RUN) && !stat_i.start_bad) begin
          state_d = stat_i.dfs_mode ? ST_DFS_SCAN : ST_BFS_SCAN;
        end
      end
      ST_BFS_SCAN: begin
        if (!stat_i.cand) begin
          state_d = stat_i.q_empty ? ST_FLUSH : ST_BFS_LOAD;
        end
      end
      ST_BFS_LOAD: state_d = ST_BFS_SCAN;
      ST_DFS_SCAN: begin
        if (!stat_i.cand) begin
          state_d = stat_i.sp_one ? ST_FLUSH : ST_DFS_LOAD;
        end
      end
      ST_DFS_LOAD: state_d = ST_DFS_SCAN;
      ST_FLUSH:    state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (cmd_i)
            CMD_CLEAR: ctrl_o.clear    = 1'b1;
            CMD_EDGE:  ctrl_o.add_edge = 1'b1;
            CMD_RUN: begin
              ctrl_o.err_out = stat_i.start_bad;
              ctrl_o.init    = !stat_i.start_bad;
            end
            default: begin
            end
          endcase
        end
      end
      ST_BFS_SCAN: begin
        ctrl_o.enqueue = stat_i.cand;
        ctrl_o.q_read  = !stat_i.cand && !stat_i.q_empty;
        ctrl_o.flush   = !stat_i.cand && stat_i.q_empty;
      end
      ST_BFS_LOAD: ctrl_o.bfs_load = 1'b1;
      ST_DFS_SCAN: begin
        ctrl_o.push  = stat_i.cand;
        ctrl_o.pop   = !stat_i.cand && !stat_i.sp_one;
        ctrl_o.flush = !stat_i.cand && stat_i.sp_one;
      end
      ST_DFS_LOAD: ctrl_o.dfs_load = 1'b1;
      default: begin
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

>>> rtl/core/graph_bfs_dfs_traversal_top.sv
`timescale 1ns / 1ps
// Graph traversal engine over a 32-vertex adjacency bit matrix. A clear or
// add-edge command leaves the engine idle. A run emits one result per visited
// vertex, in breadth-first or depth-first order, at most one per cycle, each
// shown on the result ports for a single cycle under res_valid_o; the receiver
// cannot stall, so it must take every result as it appears. A breadth-first
// run enqueues each new neighbour, then reads and loads the next vertex from
// the queue; a depth-first run descends into each new neighbour and backs out
// via the stack. Each reads a single adjacency row per cycle and moves one
// queue or stack entry per cycle. An out-of-range start gives one error result.
module graph_bfs_dfs_traversal_top #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 cmd_i,
  input  logic [gbt_pkg::VW-1:0]     from_vertex_i,
  input  logic [gbt_pkg::VW-1:0]     to_vertex_i,
  input  logic [gbt_pkg::VW-1:0]     start_req_i,
  input  logic                       cfg_we_i,
  input  logic [gbt_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [gbt_pkg::CFG_DW-1:0] cfg_wdata_i,
  output logic                       res_valid_o,
  output logic [gbt_pkg::VW-1:0]     vertex_o,
  output logic                       last_o,
  output logic                       error_o
);
  import gbt_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  gbt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  gbt_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .from_vertex_i (from_vertex_i),
    .to_vertex_i   (to_vertex_i),
    .start_req_i   (start_req_i),
    .res_valid_o   (res_valid_o),
    .vertex_o      (vertex_o),
    .last_o        (last_o),
    .error_o       (error_o)
  );

endmodule
